FILE: hw/rtl/ipmb_response_checker_top_defines.svh
// Assertion macros for the IPMB response checker
`ifndef IPMB_RESPONSE_CHECKER_TOP_DEFINES_SVH
`define IPMB_RESPONSE_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define IPMBRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define IPMBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ipmbrc_pkg.sv
// Shared types and constants of the IPMB response checker
`default_nettype none

package ipmbrc_pkg;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusHdrErr  = 2'd1,
    StatusDataErr = 2'd2,
    StatusShort   = 2'd3
  } status_e;

  // Byte positions inside a response frame
  localparam logic [7:0] HdrLen    = 8'd3;   // bytes 0..2 form the header
  localparam logic [7:0] NetFnPos  = 8'd1;
  localparam logic [7:0] CcodePos  = 8'd6;
  localparam logic [7:0] MinFrame  = 8'd7;
  localparam logic [7:0] IndexMax  = 8'hFF;
  localparam logic [7:0] ErrReturn = 8'hFF;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] net_function;
    logic [7:0] completion_code;
    logic [7:0] handler_return;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ipmbrc_in_stage.sv
// Input register stage: holds one accepted byte until the frame logic takes it
`default_nettype none

module ipmbrc_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ipmbrc_pkg::in_item_t item_i,
  input  logic                 res_full_i,
  output logic                 step_o,
  output ipmbrc_pkg::in_item_t item_o
);
  import ipmbrc_pkg::*;

  logic     valid_d, valid_q;
  in_item_t item_q;
  logic     accept;

  // A last byte moves on only when the result buffer has room.
  assign step_o     = valid_q && !(item_q.frame_end && res_full_i);
  assign in_stall_o = valid_q && !step_o;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ipmbrc_frame.sv
// Frame state: byte count, header and payload sums, held fields, result build
`default_nettype none

module ipmbrc_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ipmbrc_pkg::in_item_t item_i,
  output ipmbrc_pkg::result_t  res_o
);
  import ipmbrc_pkg::*;

  logic [7:0] idx_d, idx_q;
  logic [7:0] hsum_d, hsum_q;
  logic [7:0] psum_d, psum_q;
  logic [5:0] netfn_d, netfn_q;
  logic [7:0] ccode_d, ccode_q;
  logic [7:0] idx_nxt, hsum_nxt, psum_nxt, ccode_nxt;
  logic [5:0] netfn_nxt;
  status_e    status;

  // State after this byte, before the end-of-frame clear.
  always_comb begin
    idx_nxt   = (idx_q != IndexMax) ? idx_q + 8'd1 : idx_q;
    hsum_nxt  = hsum_q;
    psum_nxt  = psum_q;
    if (idx_q < HdrLen) begin
      hsum_nxt = hsum_q + item_i.frame_byte;
    end else begin
      psum_nxt = psum_q + item_i.frame_byte;
    end
    netfn_nxt = (idx_q == NetFnPos) ? item_i.frame_byte[7:2] : netfn_q;
    ccode_nxt = (idx_q == CcodePos) ? item_i.frame_byte : ccode_q;
  end

  // Short frame wins, then header, then data checksum.
  always_comb begin
    if (idx_nxt < MinFrame) begin
      status = StatusShort;
    end else if (hsum_nxt != 8'd0) begin
      status = StatusHdrErr;
    end else if (psum_nxt != 8'd0) begin
      status = StatusDataErr;
    end else begin
      status = StatusOk;
    end
    res_o.status          = status;
    res_o.net_function    = netfn_nxt;
    res_o.completion_code = ccode_nxt;
    res_o.handler_return  = (status == StatusOk) ? ccode_nxt : ErrReturn;
  end

  always_comb begin
    idx_d   = idx_q;
    hsum_d  = hsum_q;
    psum_d  = psum_q;
    netfn_d = netfn_q;
    ccode_d = ccode_q;
    if (step_i) begin
      if (item_i.frame_end) begin
        idx_d   = 8'd0;
        hsum_d  = 8'd0;
        psum_d  = 8'd0;
        netfn_d = 6'd0;
        ccode_d = 8'd0;
      end else begin
        idx_d   = idx_nxt;
        hsum_d  = hsum_nxt;
        psum_d  = psum_nxt;
        netfn_d = netfn_nxt;
        ccode_d = ccode_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 8'd0;
      hsum_q  <= 8'd0;
      psum_q  <= 8'd0;
      netfn_q <= 6'd0;
      ccode_q <= 8'd0;
    end else begin
      idx_q   <= idx_d;
      hsum_q  <= hsum_d;
      psum_q  <= psum_d;
      netfn_q <= netfn_d;
      ccode_q <= ccode_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ipmbrc_res_buf.sv
// Two-entry result buffer between the frame logic and the output channel
`default_nettype none

module ipmbrc_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ipmbrc_pkg::result_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output ipmbrc_pkg::result_t data_o
);
  import ipmbrc_pkg::*;

  result_t    entries_q [2];
  logic       wr_ptr_d, wr_ptr_q;
  logic       rd_ptr_d, rd_ptr_q;
  logic [1:0] cnt_d, cnt_q;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ipmb_response_checker_top.sv
// IPMB response checker: checksum and length check of one response frame per result
//
// Input channel: one frame byte per item on frame_byte_i, frame_end_i high on
// the last byte. An item is taken when in_valid_i is high and in_stall_o low.
// Output channel: one result item per frame, offered on res_valid_o and taken
// when res_stall_i is low: status (ok, header checksum error, data checksum
// error, frame too short), net function from byte 1, completion code from
// byte 6 and the handler return (completion code when ok, else 0xFF).
// Throughput: one byte per cycle, sustained, while results drain.
// The result for a last byte passes the input register, then the frame logic
// into the result buffer, which offers it on res_valid_o.
// Stall: the two-entry result buffer absorbs results while the receiver
// stalls; only a last byte waiting on a full buffer holds the input register
// and raises in_stall_o. Bytes without the end flag keep flowing.
// Reset: clears the byte count, both sums, the held fields and both buffers;
// the first byte after reset is byte 0 of a new frame.
`default_nettype none

`include "ipmb_response_checker_top_defines.svh"

module ipmb_response_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_end_i,
  // result output channel
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [1:0] status_o,
  output logic [5:0] net_function_o,
  output logic [7:0] completion_code_o,
  output logic [7:0] handler_return_o
);
  import ipmbrc_pkg::*;

  in_item_t in_item;
  in_item_t stage_item;
  logic     step;
  logic     res_full;
  logic     res_push;
  result_t  frame_res;
  result_t  out_res;

  assign in_item.frame_byte = frame_byte_i;
  assign in_item.frame_end  = frame_end_i;

  ipmbrc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .res_full_i (res_full),
    .step_o     (step),
    .item_o     (stage_item)
  );

  // Sums and counters advance once per byte leaving the input register; the last byte clears them.
  ipmbrc_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (stage_item),
    .res_o  (frame_res)
  );

  // A result exists only for the byte carrying the end flag.
  assign res_push = step && stage_item.frame_end;

  ipmbrc_res_buf u_res_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (frame_res),
    .full_o  (res_full),
    .valid_o (res_valid_o),
    .stall_i (res_stall_i),
    .data_o  (out_res)
  );

  assign status_o          = out_res.status;
  assign net_function_o    = out_res.net_function;
  assign completion_code_o = out_res.completion_code;
  assign handler_return_o  = out_res.handler_return;

  `IPMBRC_ASSERT_NOW(a_ok_returns_ccode,
    res_valid_o && (out_res.status == StatusOk),
    handler_return_o == completion_code_o,
    "ok result must return the completion code")
  `IPMBRC_ASSERT_NOW(a_err_returns_ff,
    res_valid_o && (out_res.status != StatusOk),
    handler_return_o == ErrReturn,
    "error result must return 0xFF")
  `IPMBRC_ASSERT_NEXT(a_push_shows_result, res_push, res_valid_o,
    "result pushed but not offered")
  `IPMBRC_ASSERT_NOW(a_stall_only_when_full, in_stall_o, res_full && step == 1'b0,
    "input stalled while result buffer has room")

endmodule

`default_nettype wire
